@@ src/button_short_long_press_classifier_macros.svh @@
// assertion macros used by the port-level checker file
`ifndef BUTTON_SHORT_LONG_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_SHORT_LONG_PRESS_CLASSIFIER_MACROS_SVH

// implication in the same cycle, off while reset is applied
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// implication checked in the following cycle, off while reset is applied
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// implication that also holds during reset
`define CHK_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("reset check failed");

`endif

@@ src/bsc_pkg.sv @@
// types and constants of the button press classifier
package bsc_pkg;

    localparam int unsigned TimeWidth = 32;
    localparam int unsigned CfgWidth  = 16;
    localparam int unsigned AddrWidth = 2;

    typedef enum logic [AddrWidth-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_SHORT    = 2'd1,
        REG_LONG     = 2'd2,
        REG_UNUSED   = 2'd3
    } reg_addr_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2,
        EV_BAD   = 2'd3
    } press_event_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_SHORT    = 2'd1,
        ST_LONG     = 2'd2,
        ST_RELEASED = 2'd3
    } button_status_t;

    typedef struct packed {
        logic [CfgWidth-1:0] debounce_ms;
        logic [CfgWidth-1:0] short_press_ms;
        logic [CfgWidth-1:0] long_press_ms;
    } cfg_t;

    localparam logic [CfgWidth-1:0] DebounceReset = 16'd50;
    localparam logic [CfgWidth-1:0] ShortReset    = 16'd50;
    localparam logic [CfgWidth-1:0] LongReset     = 16'd1000;

endpackage

@@ src/bsc_cfg.sv @@
// configuration registers of the button press classifier
module bsc_cfg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_addr,
    input  logic [15:0]              cfg_wdata,
    output bsc_pkg::cfg_t            cfg
);
    import bsc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms    <= DebounceReset;
            cfg_reg.short_press_ms <= ShortReset;
            cfg_reg.long_press_ms  <= LongReset;
        end
        else if (cfg_we)
        begin
            case (reg_addr_t'(cfg_addr))
                REG_DEBOUNCE: cfg_reg.debounce_ms    <= cfg_wdata;
                REG_SHORT:    cfg_reg.short_press_ms <= cfg_wdata;
                REG_LONG:     cfg_reg.long_press_ms  <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/bsc_eval.sv @@
// debounce and press state with the per-item classification logic
module bsc_eval (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [31:0]              now_ms,
    input  logic                     level_released,
    input  logic                     falling_edge,
    input  bsc_pkg::cfg_t            cfg,
    output bsc_pkg::press_event_t    press_event
);
    import bsc_pkg::*;

    logic                 debounce_armed_reg, debounce_armed_next;
    logic [TimeWidth-1:0] debounce_start_reg, debounce_start_next;
    logic                 press_armed_reg, press_armed_next;
    logic [TimeWidth-1:0] press_start_reg, press_start_next;
    button_status_t       status_reg, status_next;

    logic                 armed_e;
    logic [TimeWidth-1:0] dstart_e;
    logic [TimeWidth-1:0] since_debounce;
    logic [TimeWidth-1:0] since_press;
    logic                 settled;
    logic                 is_long;

    always_comb
    begin
        // edge handling comes before the evaluation of the same item
        armed_e  = debounce_armed_reg | falling_edge;
        dstart_e = (falling_edge && !debounce_armed_reg) ? now_ms : debounce_start_reg;
        since_debounce = now_ms - dstart_e;
        since_press    = now_ms - press_start_reg;
        settled = armed_e && (since_debounce >= {16'd0, cfg.debounce_ms});
        is_long = (status_reg == ST_LONG);

        debounce_armed_next = armed_e;
        debounce_start_next = dstart_e;
        press_armed_next    = press_armed_reg;
        press_start_next    = press_start_reg;
        status_next         = status_reg;
        press_event         = EV_NONE;

        if (settled)
        begin
            if (!level_released)
            begin
                if (!press_armed_reg && !is_long)
                begin
                    press_armed_next = 1'b1;
                    press_start_next = now_ms;
                end
                else if (press_armed_reg && !is_long &&
                         since_press >= {16'd0, cfg.long_press_ms})
                begin
                    status_next      = ST_LONG;
                    press_armed_next = 1'b0;
                    press_event      = EV_LONG;
                end
            end
            else if (press_armed_reg)
            begin
                // early release restarts the debounce and keeps the press
                debounce_start_next = now_ms;
                if (since_press >= {16'd0, cfg.short_press_ms} && !is_long)
                begin
                    press_armed_next = 1'b0;
                    status_next      = ST_SHORT;
                    press_event      = EV_SHORT;
                end
            end
            else
            begin
                debounce_armed_next = 1'b0;
                status_next         = ST_RELEASED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_armed_reg <= 1'b0;
            debounce_start_reg <= '0;
            press_armed_reg    <= 1'b0;
            press_start_reg    <= '0;
            status_reg         <= ST_IDLE;
        end
        else if (step)
        begin
            debounce_armed_reg <= debounce_armed_next;
            debounce_start_reg <= debounce_start_next;
            press_armed_reg    <= press_armed_next;
            press_start_reg    <= press_start_next;
            status_reg         <= status_next;
        end
    end

endmodule

@@ src/button_short_long_press_classifier.sv @@
// Button short/long press classifier. Each poll item carries the millisecond
// time, the button level and a falling-edge flag, and yields exactly one result
// item with the press event (none, short, long). One item is taken per clock
// unless the input is held back; an item passes an input register and then a
// result register before its result shows, and the only thing that holds the
// input back is a full result register that the downstream side does not take.
// No clearing pass follows reset. Configuration writes belong to idle periods.
module button_short_long_press_classifier (
    input  logic        clk,
    input  logic        rst_n,
    // now_ms [31:0], level_released [32], falling_edge [33], zero fill [39:34]
    input  logic [39:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // press_event [1:0], zero fill [7:2]
    output logic [7:0]  m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import bsc_pkg::*;

    logic                 in_valid_reg;
    logic [TimeWidth-1:0] now_reg;
    logic                 released_reg;
    logic                 edge_reg;
    logic                 out_valid_reg;
    press_event_t         event_reg;
    press_event_t         event_comb;
    cfg_t                 cfg;
    logic                 advance;
    logic                 step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            now_reg      <= s_tdata[31:0];
            released_reg <= s_tdata[32];
            edge_reg     <= s_tdata[33];
        end
    end

    bsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bsc_eval u_eval (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .now_ms         (now_reg),
        .level_released (released_reg),
        .falling_edge   (edge_reg),
        .cfg            (cfg),
        .press_event    (event_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            event_reg <= event_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, event_reg};

endmodule

@@ src/bsc_checker.sv @@
// port-level checks of the button press classifier and their bind
`include "button_short_long_press_classifier_macros.svh"

module bsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);
    import bsc_pkg::*;

    // a stalled result keeps its value
    `CHK_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // only the three defined event codes leave the block, fill bits are zero
    `CHK_IMPLY(a_out_code, clk, rst_n, m_tvalid, m_tdata[1:0] != EV_BAD && m_tdata[7:2] == 6'd0)
    // a new result comes from an item that was accepted and passed the input register
    `CHK_IMPLY(a_out_origin, clk, rst_n, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))
    // reset empties the result register
    `CHK_ALWAYS(a_reset_empty, clk, !rst_n, !m_tvalid)
    // an empty or draining result register never blocks the input
    `CHK_IMPLY(a_no_stall, clk, rst_n, !m_tvalid || m_tready, s_tready)

endmodule

bind button_short_long_press_classifier bsc_checker u_bsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
